FILE: hdl/sobm_pkg.sv
// Shared types and constants for the Sobel edge magnitude block.
package sobm_pkg;

  localparam int unsigned PIX_PORT_W = 8;
  localparam int unsigned MAG_W      = 8;
  localparam int unsigned ROW_W      = 12;
  localparam int unsigned COL_W      = 11;
  localparam int unsigned IW_W       = 12;
  localparam int unsigned IH_W       = 13;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 8'd1;

  localparam logic [IW_W-1:0] WIDTH_RESET  = 12'd640;
  localparam logic [IH_W-1:0] HEIGHT_RESET = 13'd480;
  localparam logic [IH_W-1:0] HEIGHT_MAX   = 13'd4096;

  typedef enum logic [2:0] {
    S_IDLE,
    S_POS,
    S_LOAD,
    S_GRAD,
    S_SQ,
    S_SUM,
    S_ROOT,
    S_OUT
  } state_t;

  typedef struct packed {
    logic take;
    logic pos;
    logic load;
    logic grad;
    logic square;
    logic sum;
    logic root;
  } ctrl_cmd_t;

  typedef struct packed {
    logic pending;
    logic root_done;
  } dp_stat_t;

endpackage

FILE: hdl/sobm_if.sv
// Stream interfaces for pixel input, magnitude output and configuration writes.
interface sobm_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel;
  logic       start_of_frame;
  modport source (output valid, pixel, start_of_frame, input ready);
  modport sink   (input valid, pixel, start_of_frame, output ready);
endinterface

interface sobm_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  magnitude;
  logic [11:0] out_row;
  logic [10:0] out_col;
  logic        run_last;
  logic        frame_done;
  modport source (output valid, magnitude, out_row, out_col, run_last, frame_done,
                  input ready);
  modport sink   (input valid, magnitude, out_row, out_col, run_last, frame_done,
                  output ready);
endinterface

interface sobm_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [12:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: hdl/sobm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sobm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: hdl/sobm_ctrl.sv
// Controller state machine sequencing position, load, gradient, square, sum, square root and output.
module sobm_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  sobm_pkg::dp_stat_t   stat,
  output sobm_pkg::ctrl_cmd_t  cmd
);

  sobm_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sobm_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sobm_pkg::S_IDLE: if (in_valid) state_nxt = sobm_pkg::S_POS;
      sobm_pkg::S_POS:  state_nxt = sobm_pkg::S_LOAD;
      sobm_pkg::S_LOAD: state_nxt = sobm_pkg::S_GRAD;
      sobm_pkg::S_GRAD: state_nxt = stat.pending ? sobm_pkg::S_SQ : sobm_pkg::S_IDLE;
      sobm_pkg::S_SQ:   state_nxt = sobm_pkg::S_SUM;
      sobm_pkg::S_SUM:  state_nxt = sobm_pkg::S_ROOT;
      sobm_pkg::S_ROOT: if (stat.root_done) state_nxt = sobm_pkg::S_OUT;
      sobm_pkg::S_OUT:  if (out_ready) state_nxt = sobm_pkg::S_GRAD;
      default:          state_nxt = sobm_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      sobm_pkg::S_IDLE: begin
        in_ready = 1'b1;
        cmd.take = in_valid;
      end
      sobm_pkg::S_POS:  cmd.pos = 1'b1;
      sobm_pkg::S_LOAD: cmd.load = 1'b1;
      sobm_pkg::S_GRAD: cmd.grad = stat.pending;
      sobm_pkg::S_SQ:   cmd.square = 1'b1;
      sobm_pkg::S_SUM:  cmd.sum = 1'b1;
      sobm_pkg::S_ROOT: cmd.root = 1'b1;
      sobm_pkg::S_OUT:  out_valid = 1'b1;
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

FILE: hdl/sobm_dp.sv
// Datapath: position counters, line buffers, 3x3 window, Sobel and square root.
module sobm_dp #(
  parameter int unsigned MAX_WIDTH  = 2048,
  parameter int unsigned PIXEL_BITS = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  sobm_pkg::ctrl_cmd_t                 cmd,
  output sobm_pkg::dp_stat_t                  stat,
  input  logic [sobm_pkg::PIX_PORT_W-1:0]     in_pixel,
  input  logic                                in_sof,
  input  logic                                cfg_we,
  input  logic [sobm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sobm_pkg::CFG_DATA_W-1:0]     cfg_data,
  output logic [sobm_pkg::MAG_W-1:0]          out_magnitude,
  output logic [sobm_pkg::ROW_W-1:0]          out_row,
  output logic [sobm_pkg::COL_W-1:0]          out_col,
  output logic                                out_last,
  output logic                                out_done
);

  localparam int unsigned AW   = $clog2(MAX_WIDTH);
  localparam int unsigned WC   = AW + 1;
  localparam int unsigned WCMP = (WC > sobm_pkg::IW_W) ? WC : sobm_pkg::IW_W;
  localparam int unsigned P    = PIXEL_BITS;
  localparam int unsigned GW   = P + 3;
  localparam int unsigned AB   = P + 2;
  localparam int unsigned SQW  = 2 * AB;
  localparam int unsigned SUMW = SQW + 1;
  localparam int unsigned VW   = 2 * P;
  localparam int unsigned RW   = P + 3;
  localparam int unsigned CNTW = $clog2(P);
  localparam int unsigned ROW_W = sobm_pkg::ROW_W;
  localparam int unsigned IH_W  = sobm_pkg::IH_W;

  // configuration
  logic [sobm_pkg::IW_W-1:0] iw_r;
  logic [IH_W-1:0]           ih_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iw_r <= sobm_pkg::WIDTH_RESET;
      ih_r <= sobm_pkg::HEIGHT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sobm_pkg::CFG_IMAGE_WIDTH:  iw_r <= cfg_data[sobm_pkg::IW_W-1:0];
        sobm_pkg::CFG_IMAGE_HEIGHT: ih_r <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [WCMP-1:0] wwide, wclamp;
  logic [WC-1:0]   w_use;
  logic [IH_W-1:0] h_use;

  always_comb begin
    wwide = WCMP'(iw_r);
    if (wwide < WCMP'(2)) wclamp = WCMP'(2);
    else if (wwide > WCMP'(MAX_WIDTH)) wclamp = WCMP'(MAX_WIDTH);
    else wclamp = wwide;
    w_use = WC'(wclamp);
    if (ih_r < IH_W'(2)) h_use = IH_W'(2);
    else if (ih_r > sobm_pkg::HEIGHT_MAX) h_use = sobm_pkg::HEIGHT_MAX;
    else h_use = ih_r;
  end

  // input capture
  logic [15:0]  pix_ext;
  logic [P-1:0] pix_r;
  logic         sof_r;

  assign pix_ext = 16'(in_pixel);

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      pix_r <= pix_ext[P-1:0];
      sof_r <= in_sof;
    end
  end

  // position counters
  logic [AW-1:0]    col_r, c_r, c0, c1;
  logic [ROW_W-1:0] row_r, r_r, r0, r2;
  logic [IH_W-1:0]  r1, rn;
  logic [WC-1:0]    cn;
  logic             cwrap;

  always_comb begin
    c0    = sof_r ? '0 : col_r;
    r0    = sof_r ? '0 : row_r;
    cwrap = WC'(c0) >= w_use;
    c1    = cwrap ? '0 : c0;
    r1    = IH_W'(r0) + (cwrap ? IH_W'(1) : IH_W'(0));
    r2    = (r1 >= h_use) ? '0 : r1[ROW_W-1:0];
    cn    = WC'(c1) + WC'(1);
    rn    = IH_W'(r2) + IH_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (cmd.pos) begin
      if (cn >= w_use) begin
        col_r <= '0;
        row_r <= (rn >= h_use) ? '0 : rn[ROW_W-1:0];
      end else begin
        col_r <= cn[AW-1:0];
        row_r <= r2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pos) begin
      c_r <= c1;
      r_r <= r2;
    end
  end

  // line buffers
  logic [P-1:0] above_rd, two_rd;

  sobm_ram #(.WIDTH(P), .DEPTH(MAX_WIDTH)) u_line_above (
    .clk   (clk),
    .we    (cmd.load),
    .waddr (c_r),
    .wdata (pix_r),
    .re    (cmd.pos),
    .raddr (c1),
    .rdata (above_rd)
  );

  sobm_ram #(.WIDTH(P), .DEPTH(MAX_WIDTH)) u_line_two_above (
    .clk   (clk),
    .we    (cmd.load),
    .waddr (c_r),
    .wdata (above_rd),
    .re    (cmd.pos),
    .raddr (c1),
    .rdata (two_rd)
  );

  // window: rows 0 two above, 1 above, 2 current; column 2 newest
  logic [P-1:0] win_r [0:8];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 9; k++) win_r[k] <= '0;
    end else if (cmd.load) begin
      for (int k = 0; k < 3; k++) begin
        win_r[k*3]   <= win_r[k*3+1];
        win_r[k*3+1] <= win_r[k*3+2];
      end
      win_r[2] <= two_rd;
      win_r[5] <= above_rd;
      win_r[8] <= pix_r;
    end
  end

  // pending results: bit0 row above left, bit1 row above right edge,
  // bit2 last row left, bit3 last row right edge
  logic [3:0] pend_r;
  logic       top_r, left_r;
  logic       r_ge1, c_ge1, c_last, r_last;

  always_comb begin
    r_ge1  = r_r != '0;
    c_ge1  = c_r != '0;
    c_last = WC'(c_r) == (w_use - WC'(1));
    r_last = IH_W'(r_r) == (h_use - IH_W'(1));
  end

  logic [3:0] sel_oh, pend_left;
  logic [1:0] sel_idx;

  always_comb begin
    sel_oh  = pend_r & (~pend_r + 4'd1);
    sel_idx = 2'd0;
    case (sel_oh)
      4'b0010: sel_idx = 2'd1;
      4'b0100: sel_idx = 2'd2;
      4'b1000: sel_idx = 2'd3;
      default: sel_idx = 2'd0;
    endcase
    pend_left = pend_r & ~sel_oh;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else if (cmd.load) begin
      pend_r <= {r_last & c_last, r_last & c_ge1, r_ge1 & c_last, r_ge1 & c_ge1};
    end else if (cmd.grad) begin
      pend_r <= pend_left;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      top_r  <= r_r == ROW_W'(1);
      left_r <= c_r == AW'(1);
    end
  end

  // window selection for current result
  logic [1:0] rt, rm, rb, cl, cx, cr;

  always_comb begin
    if (sel_idx[1]) begin
      rt = 2'd1; rm = 2'd2; rb = 2'd2;
    end else begin
      rt = top_r ? 2'd1 : 2'd0; rm = 2'd1; rb = 2'd2;
    end
    if (sel_idx[0]) begin
      cl = 2'd1; cx = 2'd2; cr = 2'd2;
    end else begin
      cl = left_r ? 2'd1 : 2'd0; cx = 2'd1; cr = 2'd2;
    end
  end

  function automatic logic [3:0] widx(input logic [1:0] rr, input logic [1:0] cc);
    widx = {2'b00, rr} * 4'd3 + {2'b00, cc};
  endfunction

  logic signed [GW-1:0] p_tl, p_ml, p_bl, p_tx, p_bx, p_tr, p_mr, p_br, gx, gy;

  always_comb begin
    p_tl = $signed(GW'(win_r[widx(rt, cl)]));
    p_ml = $signed(GW'(win_r[widx(rm, cl)]));
    p_bl = $signed(GW'(win_r[widx(rb, cl)]));
    p_tx = $signed(GW'(win_r[widx(rt, cx)]));
    p_bx = $signed(GW'(win_r[widx(rb, cx)]));
    p_tr = $signed(GW'(win_r[widx(rt, cr)]));
    p_mr = $signed(GW'(win_r[widx(rm, cr)]));
    p_br = $signed(GW'(win_r[widx(rb, cr)]));
    gx   = (p_tr + (p_mr <<< 1) + p_br) - (p_tl + (p_ml <<< 1) + p_bl);
    gy   = (p_tl + (p_tx <<< 1) + p_tr) - (p_bl + (p_bx <<< 1) + p_br);
  end

  logic [AB-1:0]    ax_r, ay_r;
  logic [GW-1:0]    ax_full, ay_full;
  logic [ROW_W-1:0] orow_r;
  logic [AW-1:0]    ocol_r;
  logic             last_r, done_r;

  assign ax_full = gx[GW-1] ? GW'(-gx) : GW'(gx);
  assign ay_full = gy[GW-1] ? GW'(-gy) : GW'(gy);

  always_ff @(posedge clk) begin
    if (cmd.grad) begin
      ax_r   <= ax_full[AB-1:0];
      ay_r   <= ay_full[AB-1:0];
      orow_r <= sel_idx[1] ? r_r : r_r - ROW_W'(1);
      ocol_r <= sel_idx[0] ? AW'(w_use - WC'(1)) : c_r - AW'(1);
      last_r <= pend_left == '0;
      done_r <= sel_idx == 2'd3;
    end
  end

  // squares, sum, digit-by-digit square root
  logic [SQW-1:0]  sqx_r, sqy_r;
  logic [SUMW-1:0] ssum;
  logic [VW-1:0]   v_r;
  logic [RW-1:0]   rem_r, rem_pre, trial;
  logic [P-1:0]    root_r;
  logic [CNTW-1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (cmd.square) begin
      sqx_r <= ax_r * ax_r;
      sqy_r <= ay_r * ay_r;
    end
  end

  assign ssum    = SUMW'(sqx_r) + SUMW'(sqy_r);
  assign rem_pre = {rem_r[RW-3:0], v_r[VW-1:VW-2]};
  assign trial   = RW'({root_r, 2'b01});

  always_ff @(posedge clk) begin
    if (cmd.sum) begin
      v_r    <= ssum[SUMW-1:5];
      rem_r  <= '0;
      root_r <= '0;
      cnt_r  <= '0;
    end else if (cmd.root) begin
      v_r   <= v_r << 2;
      cnt_r <= cnt_r + CNTW'(1);
      if (rem_pre >= trial) begin
        rem_r  <= rem_pre - trial;
        root_r <= {root_r[P-2:0], 1'b1};
      end else begin
        rem_r  <= rem_pre;
        root_r <= {root_r[P-2:0], 1'b0};
      end
    end
  end

  logic [15:0] root_ext;
  assign root_ext = 16'(root_r);

  assign stat.pending   = pend_r != '0;
  assign stat.root_done = cnt_r == CNTW'(P - 1);

  assign out_magnitude = (root_ext > 16'd255) ? 8'hFF : root_ext[7:0];
  assign out_row       = orow_r;
  assign out_col       = sobm_pkg::COL_W'(ocol_r);
  assign out_last      = last_r;
  assign out_done      = done_r;

endmodule

FILE: hdl/sobel_edge_magnitude_top.sv
// Top level of the streaming 3x3 Sobel gradient magnitude block.
// Each accepted pixel passes the position and load states, then each of its results
//   the gradient, square, sum, root and output states; no new pixel is taken meanwhile.
// A pixel with no result returns to idle from the gradient state; otherwise its pace
//   is set by the bit-per-cycle square root unit and by output stalls.
// Reset (rst_n low, synchronous): position counters, window and state cleared,
//   size registers back to 640 x 480; line buffers are not cleared.
module sobel_edge_magnitude_top #(
  parameter int unsigned MAX_WIDTH  = 2048,
  parameter int unsigned PIXEL_BITS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  sobm_in_if.sink     in_stream,
  sobm_out_if.source  out_stream,
  sobm_cfg_if.sink    cfg_port
);

  sobm_pkg::ctrl_cmd_t cmd;
  sobm_pkg::dp_stat_t  stat;
  logic                cfg_we;

  // Register writes are taken at any time; only idle writes are meaningful.
  assign cfg_port.ready = 1'b1;
  assign cfg_we         = cfg_port.valid;

  sobm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_stream.valid),
    .in_ready  (in_stream.ready),
    .out_valid (out_stream.valid),
    .out_ready (out_stream.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Datapath holds line buffers, window, gradient and square root unit.
  sobm_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .in_pixel      (in_stream.pixel),
    .in_sof        (in_stream.start_of_frame),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_port.index),
    .cfg_data      (cfg_port.data),
    .out_magnitude (out_stream.magnitude),
    .out_row       (out_stream.out_row),
    .out_col       (out_stream.out_col),
    .out_last      (out_stream.run_last),
    .out_done      (out_stream.frame_done)
  );

  // One pixel in flight: no new transfer while a result is offered.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_stream.valid |-> !in_stream.ready)
    else $error("input ready while result pending");

  // The frame's final result is also the pixel's last one.
  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_stream.valid && out_stream.frame_done |-> out_stream.run_last)
    else $error("frame_done without run_last");

  // No result is offered too soon after a pixel transfer.
  a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_stream.valid && in_stream.ready |=> !out_stream.valid ##1 !out_stream.valid)
    else $error("result too early after transfer");

endmodule

FILE: test/sobm_tb_if.sv
// Result record type shared by the Sobel edge magnitude testbench.
`timescale 1ns / 1ps
package sobm_tb_types;
  typedef struct packed {
    logic [7:0]  mag;
    logic [11:0] row;
    logic [10:0] col;
    logic        last;
    logic        done;
  } mag_result_t;
endpackage

FILE: test/sobel_edge_magnitude_top_tb.sv
// Self-checking bench for the Sobel edge magnitude block with random flow control.
`timescale 1ns / 1ps
module sobel_edge_magnitude_top_tb;

  // Scoreboard: mirrors the window pipeline and keeps the queue of pending magnitudes.
  class sobel_scoreboard;
    int unsigned width_reg, height_reg;
    bit [7:0] line1 [2048];
    bit [7:0] line2 [2048];
    bit [7:0] win [9];
    int unsigned col_cnt, row_cnt;
    sobm_tb_types::mag_result_t pending_mags[$];
    int unsigned mismatches;

    function new();
      width_reg = 640; height_reg = 480;
      col_cnt = 0; row_cnt = 0; mismatches = 0;
      foreach (win[i]) win[i] = 0;
    endfunction

    function void write_reg(bit [7:0] idx, bit [12:0] val);
      if (idx == sobm_pkg::CFG_IMAGE_WIDTH) width_reg = val[11:0];
      else if (idx == sobm_pkg::CFG_IMAGE_HEIGHT) height_reg = val;
    endfunction

    function int unsigned eff_w();
      return width_reg < 2 ? 2 : (width_reg > 2048 ? 2048 : width_reg);
    endfunction

    function int unsigned eff_h();
      return height_reg < 2 ? 2 : (height_reg > 4096 ? 4096 : height_reg);
    endfunction

    function longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res, bitv;
      res = 0; bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
        if (v >= res + bitv) begin
          v -= res + bitv;
          res = (res >> 1) + bitv;
        end else begin
          res >>= 1;
        end
        bitv >>= 2;
      end
      return res;
    endfunction

    function bit [7:0] gradient(int t, int m, int b, int l, int x, int r);
      longint gx, gy;
      longint unsigned q;
      gx = (win[t*3+r] + 2*win[m*3+r] + win[b*3+r]) - (win[t*3+l] + 2*win[m*3+l] + win[b*3+l]);
      gy = (win[t*3+l] + 2*win[t*3+x] + win[t*3+r]) - (win[b*3+l] + 2*win[b*3+x] + win[b*3+r]);
      q = int_sqrt((gx*gx + gy*gy) >> 5);
      return q > 255 ? 8'd255 : q[7:0];
    endfunction

    function void push(bit [7:0] m, int unsigned r, int unsigned c,
                       ref sobm_tb_types::mag_result_t lst[$]);
      sobm_tb_types::mag_result_t e;
      e.mag = m; e.row = r[11:0]; e.col = c[10:0]; e.last = 0; e.done = 0;
      lst.push_back(e);
    endfunction

    // Called for every accepted pixel transfer.
    function void note_pixel(bit [7:0] pix, bit sof);
      int unsigned w, h, r, c;
      bit [7:0] a1, a2;
      sobm_tb_types::mag_result_t lst[$];
      w = eff_w(); h = eff_h();
      if (sof) begin
        col_cnt = 0; row_cnt = 0;
      end
      if (col_cnt >= w) begin
        col_cnt = 0; row_cnt++;
      end
      if (row_cnt >= h) row_cnt = 0;
      r = row_cnt; c = col_cnt;
      a2 = line2[c]; a1 = line1[c];
      line2[c] = a1; line1[c] = pix;
      for (int k = 0; k < 3; k++) begin
        win[k*3] = win[k*3+1];
        win[k*3+1] = win[k*3+2];
      end
      win[2] = a2; win[5] = a1; win[8] = pix;
      if (r >= 1) begin
        if (c >= 1) push(gradient(r == 1, 1, 2, c == 1, 1, 2), r-1, c-1, lst);
        if (c == w-1) push(gradient(r == 1, 1, 2, 1, 2, 2), r-1, w-1, lst);
      end
      if (r == h-1) begin
        if (c >= 1) push(gradient(1, 2, 2, c == 1, 1, 2), r, c-1, lst);
        if (c == w-1) push(gradient(1, 2, 2, 1, 2, 2), r, w-1, lst);
      end
      if (lst.size() > 0) begin
        lst[lst.size()-1].last = 1;
        if (r == h-1 && c == w-1) lst[lst.size()-1].done = 1;
      end
      foreach (lst[i]) pending_mags.push_back(lst[i]);
      col_cnt = c + 1;
      if (col_cnt >= w) begin
        col_cnt = 0; row_cnt = r + 1;
        if (row_cnt >= h) row_cnt = 0;
      end
    endfunction

    // Called for every accepted result transfer.
    function void check_result(sobm_tb_types::mag_result_t got);
      sobm_tb_types::mag_result_t exp_r;
      if (pending_mags.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
        return;
      end
      exp_r = pending_mags.pop_front();
      if (exp_r != got) begin
        mismatches++;
        if (mismatches <= 10) $display("mismatch: expected %p got %p", exp_r, got);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  always #1 clk = ~clk;

  sobm_in_if  pix_if ();
  sobm_out_if mag_if ();
  sobm_cfg_if cfg_if ();

  sobel_edge_magnitude_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_stream(pix_if.sink), .out_stream(mag_if.source), .cfg_port(cfg_if.sink)
  );

  sobel_scoreboard sb = new();

  // Pixel source state; pixels are generated into this queue, the driver pops them.
  typedef struct packed { logic [7:0] pix; logic sof; } pixel_item_t;
  pixel_item_t pix_queue[$];
  int unsigned stall_len = 0;   // receiver hold-off request in cycles
  bit stall_mode_on = 1;
  longint unsigned cycles = 0;

  initial begin
    pix_if.valid = 0; pix_if.pixel = 0; pix_if.start_of_frame = 0;
    mag_if.ready = 0;
    cfg_if.valid = 0; cfg_if.index = sobm_pkg::CFG_IMAGE_WIDTH; cfg_if.data = 0;
  end

  // Timeout watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 2000000) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Result sink: random stall pattern, plus long hold-offs on request.
  int unsigned hold_cnt = 0;
  always @(posedge clk) begin
    if (rst_n && mag_if.valid && mag_if.ready)
      sb.check_result('{mag_if.magnitude, mag_if.out_row, mag_if.out_col,
                        mag_if.run_last, mag_if.frame_done});
    if (stall_len != 0 && hold_cnt == 0) begin
      hold_cnt <= stall_len;
      stall_len <= 0;
      mag_if.ready <= 0;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
      mag_if.ready <= (hold_cnt == 1);
    end else begin
      mag_if.ready <= stall_mode_on ? (($urandom % 8) < 5) : 1'b1;
    end
  end

  // Pixel driver: bursts with random gaps; transfers are noted in the scoreboard.
  int unsigned burst_left = 0, gap_left = 0;
  always @(posedge clk) begin
    if (pix_if.valid && pix_if.ready) sb.note_pixel(pix_if.pixel, pix_if.start_of_frame);
    if (!pix_if.valid || pix_if.ready) begin
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        pix_if.valid <= 0;
      end else if (pix_queue.size() != 0) begin
        pixel_item_t it;
        it = pix_queue.pop_front();
        pix_if.valid <= 1;
        pix_if.pixel <= it.pix;
        pix_if.start_of_frame <= it.sof;
        if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 30);
          gap_left <= ($urandom % 3 == 0) ? 0 : $urandom_range(0, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        pix_if.valid <= 0;
      end
    end
  end

  task automatic write_cfg(input logic [7:0] idx, input logic [12:0] val);
    @(posedge clk);
    cfg_if.valid <= 1; cfg_if.index <= idx; cfg_if.data <= val;
    do @(posedge clk); while (!cfg_if.ready);
    sb.write_reg(idx, val);
    cfg_if.valid <= 0;
  endtask

  // Waits until every queued pixel was taken and every expected result arrived.
  task automatic drain();
    while (pix_queue.size() != 0 || pix_if.valid || sb.pending_mags.size() != 0)
      @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  function automatic bit [7:0] rand_pixel(int mode);
    case (mode)
      0: return 8'd0;
      1: return 8'd255;
      2: return $urandom_range(0, 1) ? 8'd255 : 8'd0;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Queues one frame with start_of_frame on its first pixel.
  task automatic queue_frame(int unsigned w, int unsigned h, int mode);
    pixel_item_t it;
    for (int unsigned i = 0; i < w*h; i++) begin
      it.pix = rand_pixel(mode);
      it.sof = (i == 0);
      pix_queue.push_back(it);
    end
  endtask

  initial begin
    int unsigned w, h, n;
    pixel_item_t it;
    repeat (12) @(posedge clk);
    rst_n <= 1;

    // Directed: minimum frame sizes, extreme pixel values, edges.
    write_cfg(sobm_pkg::CFG_IMAGE_WIDTH, 13'd2);
    write_cfg(sobm_pkg::CFG_IMAGE_HEIGHT, 13'd2);
    queue_frame(2, 2, 1);
    queue_frame(2, 2, 0);
    queue_frame(2, 2, 2);
    drain();
    write_cfg(sobm_pkg::CFG_IMAGE_WIDTH, 13'd3);
    write_cfg(sobm_pkg::CFG_IMAGE_HEIGHT, 13'd3);
    queue_frame(3, 3, 2);
    drain();
    // Register values below range clamp to 2.
    write_cfg(sobm_pkg::CFG_IMAGE_WIDTH, 13'd0);
    write_cfg(sobm_pkg::CFG_IMAGE_HEIGHT, 13'd1);
    queue_frame(2, 2, 3);
    drain();

    // Long receiver hold-off while the source keeps offering pixels.
    write_cfg(sobm_pkg::CFG_IMAGE_WIDTH, 13'd5);
    write_cfg(sobm_pkg::CFG_IMAGE_HEIGHT, 13'd4);
    stall_len = 400;
    queue_frame(5, 4, 3);
    drain();

    // Random frames of small sizes.
    n = 0;
    while (n < 320) begin
      w = $urandom_range(2, 9);
      h = $urandom_range(2, 6);
      write_cfg(sobm_pkg::CFG_IMAGE_WIDTH, 13'(w));
      write_cfg(sobm_pkg::CFG_IMAGE_HEIGHT, 13'(h));
      stall_mode_on = ($urandom % 4) != 0;
      queue_frame(w, h, $urandom_range(0, 5) == 0 ? 2 : 3);
      // Partial frame, then a fresh start of frame: broken sequence.
      if ($urandom % 5 == 0)
        for (int k = 0; k < $urandom_range(1, 2*w); k++) begin
          it.pix = 8'($urandom_range(0, 255)); it.sof = 0;
          pix_queue.push_back(it);
        end
      n += pix_queue.size();
      drain();
    end

    // Largest width and height registers: only a few pixels (no results on line 0).
    write_cfg(sobm_pkg::CFG_IMAGE_WIDTH, 13'd4095);
    write_cfg(sobm_pkg::CFG_IMAGE_HEIGHT, 13'd8191);
    queue_frame(6, 1, 3);
    drain();
    // Wider 2-row frame with the receiver always ready.
    write_cfg(sobm_pkg::CFG_IMAGE_WIDTH, 13'd40);
    write_cfg(sobm_pkg::CFG_IMAGE_HEIGHT, 13'd2);
    stall_mode_on = 0;
    queue_frame(40, 2, 3);
    drain();

    if (sb.mismatches == 0 && sb.pending_mags.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

FILE: filelist.f
hdl/sobm_pkg.sv
hdl/sobm_if.sv
hdl/sobm_ram.sv
hdl/sobm_ctrl.sv
hdl/sobm_dp.sv
hdl/sobel_edge_magnitude_top.sv
test/sobm_tb_if.sv
test/sobel_edge_magnitude_top_tb.sv
